// ----- hw/rtl/bcm_pkg.sv -----
// Shared types and constants of the backlash correction move block.
package bcm_pkg;

    localparam int unsigned AXES        = 4;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned BACKLASH_W  = 20;
    localparam int unsigned FEED_W      = 26;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = FEED_W;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKLASH_X   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKLASH_Y   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKLASH_Z   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKLASH_E   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEED_LIMIT_X = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEED_LIMIT_Y = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEED_LIMIT_Z = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEED_LIMIT_E = 4'd7;

    localparam logic [FEED_W-1:0] FEED_RESET = {FEED_W{1'b1}};

    // Planned move: current and destination positions, signed Q16.16 mm
    typedef struct packed {
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic signed [POS_W-1:0] cur_z;
        logic signed [POS_W-1:0] cur_e;
        logic signed [POS_W-1:0] dst_x;
        logic signed [POS_W-1:0] dst_y;
        logic signed [POS_W-1:0] dst_z;
        logic signed [POS_W-1:0] dst_e;
    } move_t;

    // Correction move target and feed rate
    typedef struct packed {
        logic signed [POS_W-1:0] fix_x;
        logic signed [POS_W-1:0] fix_y;
        logic signed [POS_W-1:0] fix_z;
        logic signed [POS_W-1:0] fix_e;
        logic        [FEED_W-1:0] move_feed;
    } fix_t;

    // Configuration as seen by the datapath, axis 0 is X
    typedef struct packed {
        logic [AXES-1:0][BACKLASH_W-1:0] backlash;
        logic [AXES-1:0][FEED_W-1:0]     feed_limit;
    } bcm_cfg_t;

endpackage

// ----- hw/rtl/bcm_cfg_regs.sv -----
// Configuration register file: backlash distances and feed limits per axis.
module bcm_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [bcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bcm_pkg::bcm_cfg_t                  cfg
);
    import bcm_pkg::*;

    logic [AXES-1:0][BACKLASH_W-1:0] backlash_reg;
    logic [AXES-1:0][FEED_W-1:0]     feed_limit_reg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlash_reg   <= '0;
            feed_limit_reg <= {AXES{FEED_RESET}};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BACKLASH_X:   backlash_reg[0]   <= cfg_data[BACKLASH_W-1:0];
                CFG_BACKLASH_Y:   backlash_reg[1]   <= cfg_data[BACKLASH_W-1:0];
                CFG_BACKLASH_Z:   backlash_reg[2]   <= cfg_data[BACKLASH_W-1:0];
                CFG_BACKLASH_E:   backlash_reg[3]   <= cfg_data[BACKLASH_W-1:0];
                CFG_FEED_LIMIT_X: feed_limit_reg[0] <= cfg_data[FEED_W-1:0];
                CFG_FEED_LIMIT_Y: feed_limit_reg[1] <= cfg_data[FEED_W-1:0];
                CFG_FEED_LIMIT_Z: feed_limit_reg[2] <= cfg_data[FEED_W-1:0];
                CFG_FEED_LIMIT_E: feed_limit_reg[3] <= cfg_data[FEED_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.backlash   = backlash_reg;
    assign cfg.feed_limit = feed_limit_reg;

endmodule

// ----- hw/rtl/bcm_core.sv -----
// Combinational datapath: direction compare, saturated correction and feed rate.
module bcm_core (
    input  bcm_pkg::move_t                 move,
    input  bcm_pkg::bcm_cfg_t              cfg,
    input  logic [bcm_pkg::AXES-1:0]       last_dirs,
    output logic [bcm_pkg::AXES-1:0]       dirs,
    output logic                           hit,
    output bcm_pkg::fix_t                  fix
);
    import bcm_pkg::*;

    logic signed [AXES-1:0][POS_W-1:0] cur;
    logic signed [AXES-1:0][POS_W-1:0] dst;
    logic        [AXES-1:0][POS_W-1:0] pos;
    logic        [AXES-1:0]            enabled;
    logic        [AXES-1:0]            moving;
    logic        [AXES-1:0]            changed;
    logic        [FEED_W-1:0]          feed_max;
    logic        [FEED_W-1:0]          feed;

    assign cur = {move.cur_e, move.cur_z, move.cur_y, move.cur_x};
    assign dst = {move.dst_e, move.dst_z, move.dst_y, move.dst_x};

    // Direction bits, enables and the axes that flipped
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            dirs[a]    = $signed(dst[a]) < $signed(cur[a]);
            moving[a]  = dst[a] != cur[a];
            enabled[a] = cfg.backlash[a] != '0;
        end
    end

    assign changed = (dirs ^ last_dirs) & enabled;
    assign hit     = |changed;

    // Add or subtract the backlash on flipped axes, clamp to the position range
    always_comb
    begin
        logic signed [POS_W:0] sum;
        for (int a = 0; a < AXES; a++)
        begin
            if (dirs[a])
                sum = {cur[a][POS_W-1], cur[a]}
                      - $signed({{(POS_W+1-BACKLASH_W){1'b0}}, cfg.backlash[a]});
            else
                sum = {cur[a][POS_W-1], cur[a]}
                      + $signed({{(POS_W+1-BACKLASH_W){1'b0}}, cfg.backlash[a]});
            if (!changed[a])
                pos[a] = cur[a];
            else if (sum[POS_W] != sum[POS_W-1])
                pos[a] = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            else
                pos[a] = sum[POS_W-1:0];
        end
    end

    // Largest limit first, then the slowest among the moving axes
    always_comb
    begin
        feed_max = '0;
        for (int a = 0; a < AXES; a++)
        begin
            if (cfg.feed_limit[a] > feed_max)
                feed_max = cfg.feed_limit[a];
        end
        feed = feed_max;
        for (int a = 0; a < AXES; a++)
        begin
            if (moving[a] && cfg.feed_limit[a] < feed)
                feed = cfg.feed_limit[a];
        end
    end

    assign fix.fix_x     = pos[0];
    assign fix.fix_y     = pos[1];
    assign fix.fix_z     = pos[2];
    assign fix.fix_e     = pos[3];
    assign fix.move_feed = feed;

endmodule

// ----- hw/rtl/backlash_correction_move.sv -----
// Top level of the backlash correction move generator.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------
//  move     | move_valid / move_stall  | move_data  (current, destination)
//  fix      | fix_valid  / fix_stall   | fix_data   (correction target, feed)
//  cfg      | cfg_valid  / cfg_ready   | cfg_index, cfg_data
//
// An accepted item passes the input register, then the compare/add/minimum logic
// into the result register. One item per cycle is accepted while move_stall is
// low; a stalled result register is the only limit.
// A move causing no correction produces nothing but still updates the stored
// directions. Reset clears the directions to positive and loads the default
// registers. move_stall rises only while a held result is stalled and the input
// register is occupied.
module backlash_correction_move (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            move_valid,
    output logic                            move_stall,
    input  bcm_pkg::move_t                  move_data,
    output logic                            fix_valid,
    input  logic                            fix_stall,
    output bcm_pkg::fix_t                   fix_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcm_pkg::*;

    bcm_cfg_t         cfg;
    logic             s1_valid_reg;
    move_t            s1_data_reg;
    logic [AXES-1:0]  last_dirs_reg;
    logic [AXES-1:0]  dirs;
    logic             hit;
    fix_t             fix;
    logic             fix_valid_reg;
    fix_t             fix_data_reg;
    logic             advance;
    logic             s1_load;

    assign cfg_ready = 1'b1;

    bcm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcm_core u_core (
        .move      (s1_data_reg),
        .cfg       (cfg),
        .last_dirs (last_dirs_reg),
        .dirs      (dirs),
        .hit       (hit),
        .fix       (fix)
    );

    // Pipeline moves while the result register is empty or being taken
    assign advance    = !fix_valid_reg || !fix_stall;
    // Load the input register when it drains or is empty
    assign s1_load    = advance || !s1_valid_reg;
    assign move_stall = !s1_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= move_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && move_valid)
            s1_data_reg <= move_data;
    end

    // Stored directions follow every move that leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_dirs_reg <= '0;
        else if (advance && s1_valid_reg)
            last_dirs_reg <= dirs;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fix_valid_reg <= 1'b0;
        else if (advance)
            fix_valid_reg <= s1_valid_reg && hit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && hit)
            fix_data_reg <= fix;
    end

    assign fix_valid = fix_valid_reg;
    assign fix_data  = fix_data_reg;

endmodule

// ----- hw/rtl/bcm_checker.sv -----
// Port-level checks of the backlash correction move block and their binding.
module bcm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            move_valid,
    input  logic                            move_stall,
    input  bcm_pkg::move_t                  move_data,
    input  logic                            fix_valid,
    input  logic                            fix_stall,
    input  bcm_pkg::fix_t                   fix_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready
);
    import bcm_pkg::*;

    // Hold a stalled input item
    a_move_hold: assert property (@(posedge clk) disable iff (!rst_n)
        move_valid && move_stall |=> move_valid && $stable(move_data))
        else $error("stalled input item changed or vanished");

    // Hold a stalled result item
    a_fix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && fix_stall |=> fix_valid && $stable(fix_data))
        else $error("stalled result item changed or vanished");

    // Drop a result only once it has been taken
    a_fix_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(fix_valid) |-> !$past(fix_stall))
        else $error("result item dropped while stalled");

    // Stall the input only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        move_stall |-> fix_valid && fix_stall)
        else $error("input stalled with result side free");

    // Accept configuration at all times
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind backlash_correction_move bcm_checker u_bcm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .move_valid (move_valid),
    .move_stall (move_stall),
    .move_data  (move_data),
    .fix_valid  (fix_valid),
    .fix_stall  (fix_stall),
    .fix_data   (fix_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
